[rtl/bsws_pkg.sv]
// ---------------------------------------------------------------------------
// bsws_pkg: shared types and codes for the bounded stack with search
// Operation and status codes, item layouts, controller states.
// ---------------------------------------------------------------------------
`default_nettype none

package bsws_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int WORD_W     = 32;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic        [MODE_W-1:0] mode;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   data_out;
    logic        [POS_W-1:0]    position;
    logic        [STATUS_W-1:0] status;
    logic                       is_empty;
    logic        [POS_W-1:0]    count;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/bsws_stream_if.sv]
// ---------------------------------------------------------------------------
// bsws_stream_if: valid/ready channel
// One item moves at a clock edge where valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface bsws_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/bounded_stack_with_search.sv]
// ---------------------------------------------------------------------------
// bounded_stack_with_search: LIFO of signed words with a bottom-up search
// Push, pop or search per item; one result item per input item.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                                      | handshake
//  --------+-----+----------------------------------------------+------------
//  req     | in  | mode, value                                  | valid/ready
//  rsp     | out | data_out, position, status, is_empty, count  | valid/ready
//
//  Push, no-op and any refused op load their result on acceptance; a pop
//  loads it from the registered read of the entry memory; a search compares
//  entries bottom up, one per cycle through the single memory read port,
//  until a hit or the top entry.
//  Reset clears the fill count and the controller; the entry memory keeps
//  its contents and needs no clearing pass, as only entries below the fill
//  count are read. A held result stalls the finishing step until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_stack_with_search #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  bsws_stream_if.sink           req,
  bsws_stream_if.source         rsp
);

  localparam int CW = $clog2(DEPTH + 1);            // fill count width
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = CW + bsws_pkg::POS_W;          // room to mask to 7 bits
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Entry memory: one write port, one registered read port.
  logic [bsws_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bsws_pkg::WORD_W-1:0] rd_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic                        we;

  // Control and working registers.
  bsws_pkg::state_t            state, state_next;
  logic [CW-1:0]               cnt, cnt_next;    // entries held
  logic [CW-1:0]               idx, idx_next;    // entry whose read data is in rd_data
  logic [bsws_pkg::WORD_W-1:0] key, key_next;    // searched word

  // Result register.
  logic                        ov;
  bsws_pkg::out_item_t         od;
  bsws_pkg::out_item_t         res;
  logic                        load;

  logic                        can_load;
  logic                        full, empty, hit, last;
  logic [CW-1:0]               idx_inc;
  logic [EW-1:0]               cnt_ext, pos_ext;
  logic [CW-1:0]               pos_val;

  assign can_load = !ov || rsp.ready;
  assign full     = (cnt == DEPTH_C);
  assign empty    = (cnt == '0);
  assign idx_inc  = idx + 1'b1;
  assign hit      = (rd_data == key);
  assign last     = (idx_inc == cnt);
  assign cnt_ext  = {{bsws_pkg::POS_W{1'b0}}, cnt_next};
  assign pos_ext  = {{bsws_pkg::POS_W{1'b0}}, pos_val};

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    key_next   = key;
    rd_en      = 1'b0;
    rd_addr    = '0;
    we         = 1'b0;
    load       = 1'b0;
    pos_val    = '0;
    req.ready  = 1'b0;
    res        = '0;
    res.status = bsws_pkg::STAT_OK;

    case (state)
      bsws_pkg::ST_IDLE: begin
        // Immediate results need the output slot; pop and search use it later.
        req.ready = can_load;
        if (req.valid && can_load) begin
          case (req.data.mode)
            bsws_pkg::MODE_PUSH: begin
              load = 1'b1;
              if (full) begin
                res.status = bsws_pkg::STAT_OVERFLOW;
              end else begin
                we       = 1'b1;
                cnt_next = cnt + 1'b1;
              end
            end
            bsws_pkg::MODE_POP: begin
              if (empty) begin
                load       = 1'b1;
                res.status = bsws_pkg::STAT_EMPTY;
              end else begin
                cnt_next   = cnt - 1'b1;
                rd_en      = 1'b1;
                rd_addr    = AW'(cnt - 1'b1);
                state_next = bsws_pkg::ST_POP;
              end
            end
            bsws_pkg::MODE_SEARCH: begin
              if (empty) begin
                load       = 1'b1;
                res.status = bsws_pkg::STAT_EMPTY;
              end else begin
                key_next   = req.data.value;
                idx_next   = '0;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = bsws_pkg::ST_SEARCH;
              end
            end
            default: begin
              load = 1'b1;   // no-op reports the unchanged stack
            end
          endcase
        end
      end

      bsws_pkg::ST_POP: begin
        if (can_load) begin
          load         = 1'b1;
          res.data_out = rd_data;
          state_next   = bsws_pkg::ST_IDLE;
        end
      end

      bsws_pkg::ST_SEARCH: begin
        if (hit || last) begin
          // Hold rd_data (no new read) until the result can be stored.
          if (can_load) begin
            load       = 1'b1;
            state_next = bsws_pkg::ST_IDLE;
            if (hit) begin
              pos_val    = idx_inc;
              res.status = bsws_pkg::STAT_OK;
            end else begin
              res.status = bsws_pkg::STAT_NOT_FOUND;
            end
          end
        end else begin
          idx_next = idx_inc;
          rd_en    = 1'b1;
          rd_addr  = AW'(idx_inc);
        end
      end

      default: begin
        state_next = bsws_pkg::ST_IDLE;
      end
    endcase

    res.position = pos_ext[bsws_pkg::POS_W-1:0];
    res.count    = cnt_ext[bsws_pkg::POS_W-1:0];
    res.is_empty = (cnt_next == '0);
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(cnt)] <= req.data.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsws_pkg::ST_IDLE;
      cnt   <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx <= idx_next;
    key <= key_next;
    if (load) begin
      od <= res;
    end
  end

  assign rsp.valid = ov;
  assign rsp.data  = od;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_C)
    else $error("fill count above depth");

  a_search_idx: assert property (@(posedge clk) disable iff (rst)
    (state == bsws_pkg::ST_SEARCH) |-> (idx < cnt))
    else $error("search index past top of stack");

  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.data.mode == bsws_pkg::MODE_PUSH && !full)
      |=> (cnt == $past(cnt) + 1'b1))
    else $error("push did not grow the stack");

  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    (state != bsws_pkg::ST_IDLE) |-> !req.ready)
    else $error("item taken while an operation is in flight");

endmodule

`default_nettype wire

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb: self-checking bench for bounded_stack_with_search
// A directed table walks the stack through empty, full and the edge words.
// Biased random push/pop/search traffic follows. Each result item is checked
// against a typed row's value, else a behavioral stack kept by the bench.
// ---------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsws_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RAND_ITEMS   = 1500;
  localparam int CALM_FIRST   = 600;        // random items with no idling on
  localparam int CALM_LAST    = 900;        // either side of the block
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 100;        // longer than a full-depth search
  localparam int MAX_SHOWN    = 10;

  // One directed row; reps > 1 repeats it with value stepping by step.
  typedef struct {
    mode_t             mode;
    logic [WORD_W-1:0] value;
    int                reps;
    int                step;
    bit                typed;
    out_item_t         want;
  } plan_row_t;

  // Typed expectation travelling with a driven item, if the row had one.
  typedef struct {
    bit        typed;
    out_item_t want;
  } row_hint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsws_stream_if #(.T(in_item_t))  req_if ();
  bsws_stream_if #(.T(out_item_t)) rsp_if ();

  bounded_stack_with_search #(.DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the stack: words below shadow_fill are live.
  logic [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned       shadow_fill = 0;

  out_item_t   expected_q [$];   // results still owed by the block, oldest first
  row_hint_t   hint_q [$];       // one per item handed to the request channel
  plan_row_t   plan [$];
  int          mismatches = 0;
  bit          calm = 1'b0;      // no idling on either side while set
  int unsigned cycle_cnt = 0;

  // -------------------------------------------------------------------------
  // Behavioral stack: applies one item to the shadow state and returns the
  // result item the block must produce for it.
  // -------------------------------------------------------------------------
  function automatic out_item_t stack_apply(in_item_t it);
    out_item_t   r;
    int unsigned i;
    r = '0;
    r.status = STAT_OK;
    case (mode_t'(it.mode))
      MODE_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          r.status = STAT_OVERFLOW;               // refused, stack untouched
        end else begin
          shadow_words[shadow_fill] = it.value;
          shadow_fill++;
        end
      end
      MODE_POP: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;                  // underflow
        end else begin
          shadow_fill--;
          r.data_out = shadow_words[shadow_fill];
        end
      end
      MODE_SEARCH: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // bottom-up scan, first match wins
          r.status = STAT_NOT_FOUND;
          for (i = 0; i < shadow_fill && r.position == 0; i++) begin
            if (shadow_words[i] == it.value) begin
              r.position = POS_W'(i + 1);
              r.status   = STAT_OK;
            end
          end
        end
      end
      default: ;                                  // no-op mode
    endcase
    r.is_empty = (shadow_fill == 0);
    r.count    = POS_W'(shadow_fill);
    return r;
  endfunction

  function automatic out_item_t result_of(logic [WORD_W-1:0] data, int pos,
                                          status_t st, int cnt);
    out_item_t r;
    r.data_out = data;
    r.position = POS_W'(pos);
    r.status   = st;
    r.is_empty = (cnt == 0);
    r.count    = POS_W'(cnt);
    return r;
  endfunction

  function automatic void add_row(mode_t m, logic [WORD_W-1:0] v, int reps,
                                  int step, bit typed, out_item_t want);
    plan_row_t row;
    row.mode  = m;
    row.value = v;
    row.reps  = reps;
    row.step  = step;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  // Word mix: edge words, a small pool (duplicates for search), full random.
  function automatic logic [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    if (roll < 35)
      return WORD_W'(int'($urandom_range(15)) - 8);
    return $urandom;
  endfunction

  // Mode weights depend on the current burst bias so the fill level sweeps
  // between empty and full instead of hovering near one point.
  function automatic in_item_t pick_item(int bias);
    in_item_t it;
    int       roll;
    int       push_w;
    int       pop_w;
    roll   = $urandom_range(99);
    push_w = (bias == 0) ? 60 : (bias == 1) ? 15 : 35;
    pop_w  = (bias == 0) ? 15 : (bias == 1) ? 60 : 35;
    if (roll < push_w)
      it.mode = MODE_PUSH;
    else if (roll < push_w + pop_w)
      it.mode = MODE_POP;
    else if (roll < 96)
      it.mode = MODE_SEARCH;
    else
      it.mode = MODE_NOP;
    // searches mostly aim at live words so hits land at all positions
    if (it.mode == MODE_SEARCH && shadow_fill > 0 && $urandom_range(99) < 60)
      it.value = shadow_words[$urandom_range(shadow_fill - 1)];
    else
      it.value = pick_word();
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input out_item_t want,
                               input out_item_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t %s: expected data=%0d pos=%0d status=%0d empty=%0b count=%0d,",
               $realtime, what, want.data_out, want.position, want.status,
               want.is_empty, want.count,
               " got data=%0d pos=%0d status=%0d empty=%0b count=%0d",
               got.data_out, got.position, got.status, got.is_empty, got.count);
  endtask

  // -------------------------------------------------------------------------
  // Request driver. Called at a rising edge; returns at the edge where the
  // item is taken. A gap lowers valid first, so valid never sees two
  // nonblocking writes in one step.
  // -------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input bit typed,
                           input out_item_t want);
    row_hint_t hint;
    int        gap;
    gap = 0;
    if (!calm)
      while ($urandom_range(99) < 35) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hint.typed = typed;
    hint.want  = want;
    hint_q.push_back(hint);
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Result side backpressure: drops ready about a third of the time outside calm.
  always @(posedge clk) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= 35);
  end

  // -------------------------------------------------------------------------
  // Scoreboard. Request acceptance is handled before result checking in the
  // same process, so an item taken on a result's edge is queued before the check.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    row_hint_t hint;
    out_item_t predicted;
    out_item_t want;
    out_item_t got;
    if (!rst && req_if.valid && req_if.ready) begin
      hint      = hint_q.pop_front();
      predicted = stack_apply(req_if.data);
      // a typed row keeps its hand-written value; the shadow still advances
      expected_q.push_back(hint.typed ? hint.want : predicted);
    end
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected result item", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.data_out !== want.data_out || got.position !== want.position ||
            got.status !== want.status || got.is_empty !== want.is_empty ||
            got.count !== want.count)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus: directed table, then biased random bursts.
  // -------------------------------------------------------------------------
  initial begin : stimulus
    in_item_t it;
    int       n;
    int       k;
    int       bias;
    int       burst_left;

    req_if.valid = 1'b0;
    req_if.data  = '0;

    // empty stack: pop and search underflow, no-op reports empty
    add_row(MODE_POP,    32'h0000_0000, 1, 0, 1, result_of(0, 0, STAT_EMPTY, 0));
    add_row(MODE_SEARCH, 32'h0000_0005, 1, 0, 1, result_of(0, 0, STAT_EMPTY, 0));
    add_row(MODE_NOP,    32'h0000_0000, 1, 0, 1, result_of(0, 0, STAT_OK, 0));
    // edge words; together they toggle every value bit
    add_row(MODE_PUSH,   32'h7FFF_FFFF, 1, 0, 1, result_of(0, 0, STAT_OK, 1));
    add_row(MODE_PUSH,   32'h8000_0000, 1, 0, 1, result_of(0, 0, STAT_OK, 2));
    add_row(MODE_PUSH,   32'h0000_0000, 1, 0, 1, result_of(0, 0, STAT_OK, 3));
    add_row(MODE_PUSH,   32'hFFFF_FFFF, 1, 0, 1, result_of(0, 0, STAT_OK, 4));
    add_row(MODE_SEARCH, 32'h8000_0000, 1, 0, 1, result_of(0, 2, STAT_OK, 4));
    add_row(MODE_SEARCH, 32'hFFFF_FFFF, 1, 0, 1, result_of(0, 4, STAT_OK, 4));
    add_row(MODE_SEARCH, 32'h0000_3039, 1, 0, 1,
            result_of(0, 0, STAT_NOT_FOUND, 4));
    // duplicate word: search must report the lower copy
    add_row(MODE_PUSH,   32'h7FFF_FFFF, 1, 0, 1, result_of(0, 0, STAT_OK, 5));
    add_row(MODE_SEARCH, 32'h7FFF_FFFF, 1, 0, 1, result_of(0, 1, STAT_OK, 5));
    add_row(MODE_POP,    32'h0000_0000, 1, 0, 1,
            result_of(32'h7FFF_FFFF, 0, STAT_OK, 4));
    add_row(MODE_NOP,    32'hFFFF_FFFF, 1, 0, 1, result_of(0, 0, STAT_OK, 4));
    add_row(MODE_POP,    32'h0000_0000, 4, 0, 0, '0);
    add_row(MODE_POP,    32'h0000_0000, 1, 0, 1, result_of(0, 0, STAT_EMPTY, 0));
    // fill to the brim with distinct words, then overflow
    add_row(MODE_PUSH,   32'h0000_1000, DEPTH, 3, 0, '0);
    add_row(MODE_PUSH,   32'h0000_0005, 1, 0, 1,
            result_of(0, 0, STAT_OVERFLOW, DEPTH));
    add_row(MODE_SEARCH, 32'h0000_10BD, 1, 0, 1, result_of(0, DEPTH, STAT_OK, DEPTH));
    add_row(MODE_SEARCH, 32'h0000_1000, 1, 0, 1, result_of(0, 1, STAT_OK, DEPTH));
    add_row(MODE_SEARCH, 32'h0000_0FFF, 1, 0, 1,
            result_of(0, 0, STAT_NOT_FOUND, DEPTH));
    add_row(MODE_NOP,    32'h0000_0000, 1, 0, 1, result_of(0, 0, STAT_OK, DEPTH));
    // drain to empty and underflow once more
    add_row(MODE_POP,    32'h0000_0000, DEPTH, 0, 0, '0);
    add_row(MODE_POP,    32'h0000_0000, 1, 0, 1, result_of(0, 0, STAT_EMPTY, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      for (n = 0; n < plan[r].reps; n++) begin
        it.mode  = plan[r].mode;
        it.value = plan[r].value + n * plan[r].step;
        send_item(it, plan[r].typed, plan[r].want);
      end
    end

    // random bursts, each with its own push/pop bias
    burst_left = 0;
    bias       = 0;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (burst_left == 0) begin
        bias       = $urandom_range(2);
        burst_left = $urandom_range(120, 20);
      end
      burst_left--;
      calm <= (k >= CALM_FIRST && k < CALM_LAST);
      it = pick_item(bias);
      send_item(it, 1'b0, '0);
    end

    req_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_q.size() != 0) begin
      mismatches += expected_q.size();
      $display("%0d expected result items never arrived", expected_q.size());
    end
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
